@@ design/pp_pkg.sv @@
// Shared types and constants for the polygon perimeter block.
package pp_pkg;

  // Largest value of the perimeter accumulator (unsigned Q.4, 32 bits)
  localparam int unsigned SUM_BITS = 32;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_DIFF  = 7'b000_0010,
    ST_SQR   = 7'b000_0100,
    ST_ADD   = 7'b000_1000,
    ST_ROOT  = 7'b001_0000,
    ST_ACC   = 7'b010_0000,
    ST_EMIT  = 7'b100_0000
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture an accepted vertex
    logic diff;       // form |dx| and |dy| of the current edge
    logic closing;    // edge runs from current vertex back to the first one
    logic square;     // square both differences
    logic radicand;   // add squares, arm the root engine
    logic root_step;  // one bit of the square root
    logic acc;        // saturating add of the edge length
    logic emit;       // load output word, clear polygon state
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic have_first; // a vertex of the current polygon is held
    logic last;       // held vertex closes the polygon
    logic root_last;  // this root step is the final one
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage

@@ design/polygon_perimeter.sv @@
// Top level of the polygon perimeter block: controller, datapath, checks.
//
//  channel  dir  word contents (lowest bit up)           end marker
//  s_*      in   tdata: x_coord, y_coord (Q12.4 each)    tlast: last_vertex
//  m_*      out  tdata: perimeter (Q.4, 32 bits)         tuser: saturated
//
// A vertex that opens a polygon and is not last is only captured; the input stays ready.
// Any later vertex passes through the states DIFF, SQR, ADD, ROOT and ACC: the square
// root engine yields one bit a cycle over COORD_BITS + 1 steps.
// The last vertex runs the root engine twice (closing edge), then waits in EMIT
// until the output register is free.
// Reset is synchronous; it clears the sequencer, the running sum and the
// output valid. A stalled output word blocks only the next polygon's end.
module polygon_perimeter
  import pp_pkg::*;
#(
  parameter int COORD_BITS = 16
)
(
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,  // x_coord, y_coord
  input  logic                                    s_tlast,  // last_vertex
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [SUM_BITS-1:0]                     m_tdata,  // perimeter
  output logic [0:0]                              m_tuser   // saturated
);

  cmd_t    cmd;
  status_t sts;
  logic    sat_flag;

  pp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pp_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .x_in      (s_tdata[COORD_BITS-1:0]),
    .y_in      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .last_in   (s_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .perimeter (m_tdata),
    .saturated (sat_flag)
  );

  assign m_tuser = sat_flag;

  // A saturated perimeter always reads as the full-scale value
  a_sat_is_max: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == SUM_MAX))
    else $error("saturated word without full-scale perimeter");

  // A vertex that does not close the polygon never starts an output word
  a_no_early_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tlast) |=> !$rose(m_tvalid))
    else $error("output word raised by a non-final vertex");

  // No vertex is taken while the root engine is busy
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.root_step |-> !s_tready)
    else $error("input accepted during square root");

endmodule

@@ design/pp_ctrl.sv @@
// Sequencer for the perimeter block: one vertex at a time, edge by edge.
module pp_ctrl
  import pp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tlast,
  output logic    s_tready,
  output cmd_t    cmd,
  input  status_t sts
);

  state_t state, state_next;
  logic   close_edge, close_edge_next;

  // Hold state and the closing-edge flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      close_edge <= 1'b0;
    end else begin
      state      <= state_next;
      close_edge <= close_edge_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Decode state into commands and pick the next state
  always_comb begin
    state_next      = state;
    close_edge_next = close_edge;
    cmd             = '0;
    cmd.closing     = close_edge;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.have_first) begin
            state_next = ST_DIFF;
          end else if (s_tlast) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.square = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.radicand = 1'b1;
        state_next   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last && !close_edge) begin
          // go round once more for the edge back to the first vertex
          close_edge_next = 1'b1;
          state_next      = ST_DIFF;
        end else if (sts.last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          close_edge_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next      = ST_IDLE;
        close_edge_next = 1'b0;
      end
    endcase
  end

endmodule

@@ design/pp_dpath.sv @@
// Datapath: vertex registers, squarers, bit-serial square root, accumulator.
module pp_dpath
  import pp_pkg::*;
#(
  parameter int COORD_BITS = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COORD_BITS-1:0] x_in,
  input  logic [COORD_BITS-1:0] y_in,
  input  logic                  last_in,
  input  cmd_t                  cmd,
  output status_t               sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SUM_BITS-1:0]   perimeter,
  output logic                  saturated
);

  localparam int DW = COORD_BITS + 1;             // |difference| width
  localparam int NI = COORD_BITS + 1;             // root bits = iterations
  localparam int RW = 2 * NI;                     // radicand width
  localparam int MW = NI + 4;                     // remainder work width
  localparam int CW = $clog2(NI + 1);             // step counter width
  localparam int AW = ((NI > SUM_BITS) ? NI : SUM_BITS) + 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(NI - 1);

  logic [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y, cur_x, cur_y;
  logic                  have_first, last;
  logic [DW-1:0]         dx, dy;
  logic [RW-1:0]         sqx, sqy, rad;
  logic [MW-3:0]         rem;
  logic [NI-1:0]         root;
  logic [CW-1:0]         step;
  logic [SUM_BITS-1:0]   running_sum;
  logic                  sum_saturated;

  logic [COORD_BITS-1:0] ax, ay;
  logic [DW-1:0]         diff_x, diff_y;
  logic [MW-1:0]         rem_sh, trial;
  logic                  fits;
  logic [AW-1:0]         sum_ext;
  logic                  over;

  // Select the far end of the edge and take signed differences
  always_comb begin
    ax     = cmd.closing ? first_x : prev_x;
    ay     = cmd.closing ? first_y : prev_y;
    diff_x = {ax[COORD_BITS-1], ax} - {cur_x[COORD_BITS-1], cur_x};
    diff_y = {ay[COORD_BITS-1], ay} - {cur_y[COORD_BITS-1], cur_y};
  end

  // One root bit: bring down two radicand bits, try to subtract
  always_comb begin
    rem_sh = {rem, rad[RW-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Saturating add of the edge length
  always_comb begin
    sum_ext = AW'(running_sum) + AW'(root);
    over    = (sum_ext[AW-1:SUM_BITS] != '0);
  end

  // Vertex registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= x_in;
      cur_y <= y_in;
      last  <= last_in;
      if (!have_first) begin
        first_x <= x_in;
        first_y <= y_in;
        prev_x  <= x_in;
        prev_y  <= y_in;
      end
    end
    if (cmd.diff && !cmd.closing) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

  // Edge arithmetic: magnitudes and squares
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx <= diff_x[DW-1] ? (~diff_x + DW'(1)) : diff_x;
      dy <= diff_y[DW-1] ? (~diff_y + DW'(1)) : diff_y;
    end
    if (cmd.square) begin
      sqx <= RW'(dx * dx);
      sqy <= RW'(dy * dy);
    end
  end

  // Square root engine, one result bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.radicand) begin
      rad  <= sqx + sqy;
      rem  <= '0;
      root <= '0;
      step <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[RW-3:0], 2'b00};
      step <= step + CW'(1);
      if (fits) begin
        rem  <= (MW-2)'(rem_sh - trial);
        root <= {root[NI-2:0], 1'b1};
      end else begin
        rem  <= (MW-2)'(rem_sh);
        root <= {root[NI-2:0], 1'b0};
      end
    end
  end

  // Polygon state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first    <= 1'b0;
      running_sum   <= '0;
      sum_saturated <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cmd.load) begin
        have_first <= 1'b1;
      end
      if (cmd.acc) begin
        if (over) begin
          running_sum   <= SUM_MAX;
          sum_saturated <= 1'b1;
        end else begin
          running_sum <= sum_ext[SUM_BITS-1:0];
        end
      end
      if (cmd.emit) begin
        m_tvalid      <= 1'b1;
        have_first    <= 1'b0;
        running_sum   <= '0;
        sum_saturated <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      perimeter <= running_sum;
      saturated <= sum_saturated;
    end
  end

  assign sts.have_first = have_first;
  assign sts.last       = last;
  assign sts.root_last  = (step == LAST_STEP);
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule
